/* rtl/core/sorted_table_binary_search_top_assert.svh */
// Assertion macros for the checker file (stb_checker.sv).
// Each macro takes a label, a clock, an active-low reset, an antecedent,
// a consequent and a message string.
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define STB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define STB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/stb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package stb_pkg;

    // Fixed field widths of the ports.
    localparam int CNT_W   = 8;
    localparam int IDX_W   = 7;
    localparam int KEY_W   = 32;

    localparam logic [CNT_W-1:0] ENTRY_COUNT_RST = 8'd128;

    // Item kinds.
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

endpackage
`default_nettype wire

/* rtl/core/stb_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module stb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/core/sorted_table_binary_search_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Binary search over a table of signed 32-bit words held in one RAM.
// Input channel (i_in_valid / o_in_ready): a word with i_kind = write stores
// i_entry_value at i_entry_index and gives no result; i_kind = search looks
// for i_entry_value among the first entry_count entries (saturated to the
// table depth). Each search gives one result word on the output channel
// (o_out_valid / i_out_ready): o_found and o_match_index (0 on a miss).
// The entry_count register is written through i_cfg_we / i_cfg_data; the
// user must write it only while the block is idle, which the block does
// not enforce. It resets to 128.
// Writes stream back to back while the block is idle. A search of P probes
// loads its bounds, then for each probe sets the RAM read address (S_PROBE)
// and compares on the registered read data (S_CMP); a miss ends with the
// bound check in S_PROBE, and S_DONE loads the output register. For 128
// entries P is at most 8. The one RAM read port sets the search time. The
// next word is accepted in the cycle after the result is loaded.
// Stall: the output register holds a result until taken; the block keeps
// accepting words meanwhile, and a later search waits in its final state
// only if the previous result is still pending.
// Reset: control state clears and entry_count returns to 128; table
// contents are undefined until written, with no clearing pass.
module sorted_table_binary_search_top #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [stb_pkg::CNT_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_kind,
    input  logic [stb_pkg::IDX_W-1:0]         i_entry_index,
    input  logic signed [stb_pkg::KEY_W-1:0]  i_entry_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_found,
    output logic [stb_pkg::IDX_W-1:0]         o_match_index
);
    import stb_pkg::*;

    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int WEXT_W = (AW > IDX_W) ? AW : IDX_W;
    localparam int REXT_W = (AW > CNT_W) ? AW : CNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_DONE
    } t_state;

    t_state                    r_state;
    logic [CNT_W-1:0]          r_entry_count;
    logic signed [KEY_W-1:0]   r_key;
    logic [CNT_W-1:0]          r_low;    // first candidate index
    logic [CNT_W-1:0]          r_hi;     // one past last candidate index
    logic [CNT_W-1:0]          r_mid;
    logic                      r_hit;
    logic [IDX_W-1:0]          r_where;
    logic                      r_out_valid;
    logic                      r_found;
    logic [IDX_W-1:0]          r_match_index;

    logic                      w_accept;
    logic [CNT_W-1:0]          w_n;
    logic [CNT_W:0]            w_sum;
    logic [CNT_W-1:0]          w_mid;
    logic [REXT_W-1:0]         w_mid_ext;
    logic [WEXT_W-1:0]         w_widx_ext;
    logic                      w_wr_en;
    logic [KEY_W-1:0]          w_rdata;
    logic                      w_out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Saturate the searched count to the table depth.
    assign w_n = (32'(r_entry_count) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                         : r_entry_count;

    // Floor of the midpoint of [low, hi-1]; only used while hi > low.
    assign w_sum     = {1'b0, r_low} + {1'b0, r_hi} - {{CNT_W{1'b0}}, 1'b1};
    assign w_mid     = w_sum[CNT_W:1];
    assign w_mid_ext = REXT_W'(w_mid);

    // Drop writes beyond the table.
    assign w_widx_ext = WEXT_W'(i_entry_index);
    assign w_wr_en    = w_accept && (i_kind == KIND_WRITE)
                        && (32'(i_entry_index) < 32'(TABLE_DEPTH));

    // Writes happen only in idle and reads only during a search, so the
    // state machine itself keeps them from touching the same entry at once.
    stb_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (w_widx_ext[AW-1:0]),
        .i_wdata (i_entry_value),
        .i_raddr (w_mid_ext[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_entry_count <= ENTRY_COUNT_RST;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_entry_count <= i_cfg_data;
            end

            // Release the output word once taken, unless a new one loads now.
            if (r_out_valid && i_out_ready && !((r_state == S_DONE) && w_out_free)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_kind == KIND_SEARCH)) begin
                        r_key   <= i_entry_value;
                        r_low   <= '0;
                        r_hi    <= w_n;
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (r_low >= r_hi) begin
                        // Empty range: miss.
                        r_hit   <= 1'b0;
                        r_where <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_mid   <= w_mid;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (r_key == $signed(w_rdata)) begin
                        r_hit   <= 1'b1;
                        r_where <= r_mid[IDX_W-1:0];
                        r_state <= S_DONE;
                    end else if (r_key < $signed(w_rdata)) begin
                        r_hi    <= r_mid;
                        r_state <= S_PROBE;
                    end else begin
                        r_low   <= r_mid + {{(CNT_W-1){1'b0}}, 1'b1};
                        r_state <= S_PROBE;
                    end
                end
                S_DONE: begin
                    // Hold until the output register is free.
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_found       <= r_hit;
                        r_match_index <= r_where;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_match_index = r_match_index;

endmodule
`default_nettype wire

/* rtl/core/stb_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_table_binary_search_top_assert.svh"
module stb_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    input  wire                              o_in_ready,
    input  wire                              i_kind,
    input  wire                              o_out_valid,
    input  wire                              i_out_ready,
    input  wire                              o_found,
    input  wire [stb_pkg::IDX_W-1:0]         o_match_index
);
    import stb_pkg::*;

    // Stalled result word holds.
    `STB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_found) && $stable(o_match_index),
        "output word changed while stalled")

    // A miss reports index zero.
    `STB_ASSERT_SAME(a_miss_zero, i_clk, i_rst_n,
        o_out_valid && !o_found,
        o_match_index == '0,
        "miss with nonzero index")

    // A write taken while no result is pending creates none.
    `STB_ASSERT_NEXT(a_write_silent, i_clk, i_rst_n,
        i_in_valid && o_in_ready && (i_kind == KIND_WRITE) && !o_out_valid,
        !o_out_valid,
        "write produced a result")

    // A search keeps the input side closed in the next cycle.
    `STB_ASSERT_NEXT(a_search_busy, i_clk, i_rst_n,
        i_in_valid && o_in_ready && (i_kind == KIND_SEARCH),
        !o_in_ready,
        "input open right after a search")

endmodule

bind sorted_table_binary_search_top stb_checker u_stb_checker (.*);
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import stb_pkg::*;

    localparam int TABLE_WORDS     = 128;
    // Cycles without any handshake before the run is declared hung.
    localparam int STALL_LIMIT     = 4000;
    // Long receiver hold-off used to back the block up.
    localparam int HOLD_OFF_CYCLES = 300;
    // Wait after the last answer drains; leave margin for a trailing word.
    localparam int SETTLE_CYCLES   = 40;
    localparam int RANDOM_ITEMS    = 390;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

    typedef enum int {FILL_WIDE, FILL_NARROW, FILL_SCRAMBLED} fill_style_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] index;
    } search_answer_t;

    // Keeps a private copy of the table and the entry count, predicts the
    // answer of every accepted search and matches answers in order.
    class search_ledger;
        logic signed [KEY_W-1:0] table_words [TABLE_WORDS];
        logic [CNT_W-1:0]        count_reg;
        search_answer_t          pending[$];
        int                      fails;

        function new();
            count_reg = ENTRY_COUNT_RST;
            fails     = 0;
        endfunction

        function void set_count(logic [CNT_W-1:0] count);
            count_reg = count;
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        function search_answer_t predict_search(logic signed [KEY_W-1:0] key);
            int             lo;
            int             hi;
            int             mid;
            bit             hit;
            search_answer_t answer;
            answer = '0;
            hit    = 1'b0;
            lo     = 0;
            hi     = ((count_reg > TABLE_WORDS) ? TABLE_WORDS : int'(count_reg)) - 1;
            while (lo <= hi && !hit) begin
                mid = (lo + hi) / 2;
                if (key == table_words[mid]) begin
                    hit          = 1'b1;
                    answer.found = 1'b1;
                    answer.index = mid[IDX_W-1:0];
                end else if (key < table_words[mid]) begin
                    hi = mid - 1;
                end else begin
                    lo = mid + 1;
                end
            end
            return answer;
        endfunction

        function void note_word(logic kind, logic [IDX_W-1:0] idx,
                                logic signed [KEY_W-1:0] value);
            if (kind == KIND_WRITE) begin
                table_words[idx] = value;
            end else begin
                pending.push_back(predict_search(value));
            end
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            fails++;
        endtask

        task check_answer(logic found, logic [IDX_W-1:0] idx);
            search_answer_t want;
            if (pending.size() == 0) begin
                report($sformatf("result word (found %0d index %0d) with no search waiting",
                                 found, idx));
            end else begin
                want = pending.pop_front();
                if (found !== want.found)
                    report($sformatf("found %0d, expected %0d", found, want.found));
                if (idx !== want.index)
                    report($sformatf("match_index %0d, expected %0d", idx, want.index));
            end
        endtask
    endclass

    // Every block input starts at a known value.
    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_we      = 1'b0;
    logic [CNT_W-1:0]        i_cfg_data    = '0;
    logic                    i_in_valid    = 1'b0;
    logic                    o_in_ready;
    logic                    i_kind        = KIND_WRITE;
    logic [IDX_W-1:0]        i_entry_index = '0;
    logic signed [KEY_W-1:0] i_entry_value = '0;
    logic                    o_out_valid;
    logic                    i_out_ready   = 1'b0;
    logic                    o_found;
    logic [IDX_W-1:0]        o_match_index;

    search_ledger ledger = new();

    // Stimulus-side view of the table: which entries hold data and what.
    // Used only to pick keys and to keep searches off unwritten entries.
    logic signed [KEY_W-1:0] shadow  [TABLE_WORDS];
    bit                      written [TABLE_WORDS];
    int                      items_sent    = 0;
    int                      steady_in     = 0;
    int                      steady_out    = 0;
    bit                      hold_off_now  = 1'b0;

    always #5 i_clk = ~i_clk;

    sorted_table_binary_search_top #(
        .TABLE_DEPTH(TABLE_WORDS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_match_index (o_match_index)
    );

    // Random idle length for either side. Mostly zero or short, now and then
    // long, and occasionally a steady run of back-to-back words.
    function automatic int pick_gap(bit out_side);
        int r;
        if (out_side && steady_out > 0) begin
            steady_out--;
            return 0;
        end
        if (!out_side && steady_in > 0) begin
            steady_in--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            if (out_side) steady_out = $urandom_range(15, 50);
            else          steady_in  = $urandom_range(15, 50);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 80);
    endfunction

    // Choose a search key: mostly a stored value or its neighbor, else an
    // extreme or pure noise.
    function automatic logic signed [KEY_W-1:0] pick_key(int n);
        int                      r;
        logic signed [KEY_W-1:0] key;
        r   = $urandom_range(0, 99);
        key = $urandom();
        if (n > 0 && r < 45) begin
            key = shadow[$urandom_range(0, n - 1)];
        end else if (n > 0 && r < 70) begin
            key = shadow[$urandom_range(0, n - 1)];
            key = $urandom_range(0, 1) ? key + 1 : key - 1;
        end else if (r < 82) begin
            case ($urandom_range(0, 3))
                0: key = KEY_MIN;
                1: key = KEY_MAX;
                2: key = '0;
                default: key = '1;
            endcase
        end
        return key;
    endfunction

    // Offer one word and hold it until accepted. Valid is only lowered when
    // an idle gap follows, so back-to-back words never toggle it.
    task automatic send_word(input logic kind, input logic [IDX_W-1:0] idx,
                             input logic signed [KEY_W-1:0] value);
        int gap;
        gap = pick_gap(1'b0);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_entry_index <= idx;
        i_entry_value <= value;
        if (kind == KIND_WRITE) begin
            shadow[idx]  = value;
            written[idx] = 1'b1;
        end
        items_sent++;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // The index field is unused by a search; drive noise on it.
    task automatic send_search(input logic signed [KEY_W-1:0] key);
        send_word(KIND_SEARCH, IDX_W'($urandom_range(0, TABLE_WORDS - 1)), key);
    endtask

    // Load entries 0..n-1. Wide and narrow fills are ascending (narrow
    // gives duplicates); a scrambled fill leaves the table unsorted.
    task automatic fill_table(input int n, input fill_style_t style);
        longint step;
        longint v;
        int     i;
        step = 64'd4294967295 / (n + 1);
        v    = longint'(signed'($urandom()));
        for (i = 0; i < n; i++) begin
            case (style)
                FILL_WIDE: v = longint'(KEY_MIN) + i * step
                               + longint'($urandom_range(0, step / 2));
                FILL_NARROW: if (i > 0) v = v + longint'($urandom_range(0, 2));
                default: v = longint'(signed'($urandom()));
            endcase
            if (v > longint'(KEY_MAX)) v = longint'(KEY_MAX);
            send_word(KIND_WRITE, i[IDX_W-1:0], v[KEY_W-1:0]);
        end
    endtask

    // Drop valid, drain every pending answer, then give a trailing write
    // time to finish before anything touches the register.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (ledger.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_entry_count(input logic [CNT_W-1:0] count);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= count;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Sample every handshake at the edge that completes it. Check answers
    // before noting new words; an answer always belongs to an older search.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                ledger.check_answer(o_found, o_match_index);
            if (i_in_valid && o_in_ready)
                ledger.note_word(i_kind, i_entry_index, i_entry_value);
            if (i_cfg_we)
                ledger.set_count(i_cfg_data);
        end
    end

    // Result side: take answers with random gaps. On request, hold off for
    // a long stretch so the output register fills and the input stalls.
    initial begin : result_taker
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_now) begin
                hold_off_now = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            gap = pick_gap(1'b1);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Watchdog: end the run if no word moves on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int          cnt;
        int          n;
        int          r;
        int          i;
        int          j;
        int          burst;
        int          phase_no;
        int          target;
        bit          prefix_ok;
        fill_style_t style;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Keep the reset entry count of 128 at first: fill
        // the whole table ascending with both extremes at the ends.
        fill_table(TABLE_WORDS, FILL_WIDE);
        send_word(KIND_WRITE, '0, KEY_MIN);
        send_word(KIND_WRITE, IDX_W'(TABLE_WORDS - 1), KEY_MAX);
        send_search(KEY_MIN);              // hit at index 0, not a miss
        send_search(KEY_MAX);              // hit at the last entry
        send_search(shadow[63]);           // hit on the first probe
        send_search(shadow[64]);
        send_search(shadow[0] + 1);        // miss between two entries
        send_search(shadow[100] - 1);
        send_search('0);
        send_search('1);

        // Zero entries searched: always a miss.
        set_entry_count('0);
        send_search(KEY_MIN);
        send_search(shadow[5]);

        // Single entry.
        set_entry_count(8'd1);
        send_search(KEY_MIN);
        send_search(KEY_MAX);
        send_search(shadow[1]);

        // Counts above the depth saturate to the full table.
        set_entry_count(8'd255);
        send_search(KEY_MAX);
        send_search(shadow[17]);
        set_entry_count(8'd129);
        send_search(shadow[100]);

        set_entry_count(8'd2);
        send_search(shadow[1]);
        send_search(shadow[0]);

        // Break the order and search across the damage.
        set_entry_count(8'd128);
        send_word(KIND_WRITE, 7'd40, KEY_MAX);
        send_search(KEY_MAX);
        send_search(shadow[41]);
        send_search(shadow[39]);

        // Random phases: new entry count, refill the searched prefix when it
        // is incomplete or by chance, then a burst of mostly searches with
        // stray writes mixed in.
        target   = items_sent + RANDOM_ITEMS;
        phase_no = 0;
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 12)      cnt = $urandom_range(0, 3);
            else if (r < 22) cnt = $urandom_range(129, 255);
            else if (r < 32) cnt = TABLE_WORDS;
            else if (r < 80) cnt = $urandom_range(4, 20);
            else             cnt = $urandom_range(21, 127);
            set_entry_count(cnt[CNT_W-1:0]);
            n = (cnt > TABLE_WORDS) ? TABLE_WORDS : cnt;

            // Never let a search probe an entry that was never written.
            prefix_ok = 1'b1;
            for (i = 0; i < n; i++)
                if (!written[i]) prefix_ok = 1'b0;
            if (!prefix_ok || $urandom_range(0, 2) == 0) begin
                r     = $urandom_range(0, 9);
                style = (r < 7) ? FILL_WIDE : (r < 9) ? FILL_NARROW : FILL_SCRAMBLED;
                fill_table(n, style);
            end

            burst = $urandom_range(12, 35);
            for (j = 0; j < burst; j++) begin
                if ((phase_no == 2 || phase_no == 8) && j == burst / 2)
                    hold_off_now = 1'b1;
                if ($urandom_range(0, 99) < 85)
                    send_search(pick_key(n));
                else
                    send_word(KIND_WRITE, IDX_W'($urandom_range(0, TABLE_WORDS - 1)),
                              $urandom());
            end
            phase_no++;
        end

        // Drain and let any stray result show up before judging.
        wait_idle();
        if (ledger.fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
